### hdl/apv_pkg.sv
package apv_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK            = 3'd0;
    localparam status_t ST_NOT_ABSOLUTE  = 3'd1;
    localparam status_t ST_TOO_LONG      = 3'd2;
    localparam status_t ST_NULL_BYTE     = 3'd3;
    localparam status_t ST_EMPTY_COMP    = 3'd4;
    localparam status_t ST_COMP_TOO_LONG = 3'd5;
    localparam status_t ST_DOTDOT        = 3'd6;
    localparam status_t ST_BAD_BYTE      = 3'd7;

    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_MAX_PATH  = 3'd0;
    localparam reg_index_t REG_MAX_COMP  = 3'd1;
    localparam reg_index_t REG_ALLOWED_0 = 3'd2;
    localparam reg_index_t REG_ALLOWED_1 = 3'd3;
    localparam reg_index_t REG_ALLOWED_2 = 3'd4;
    localparam reg_index_t REG_ALLOWED_3 = 3'd5;

    localparam int PATH_CNT_W = 17;
    localparam int COMP_CNT_W = 9;

    localparam logic [PATH_CNT_W-1:0] PATH_COUNT_MAX = '1;
    localparam logic [COMP_CNT_W-1:0] COMP_COUNT_MAX = '1;

    localparam logic [7:0] SLASH_BYTE = 8'h2f;
    localparam logic [7:0] DOT_BYTE   = 8'h2e;
    localparam logic [7:0] NULL_BYTE  = 8'h00;

    localparam logic [15:0] MAX_PATH_RESET  = 16'd4096;
    localparam logic [7:0]  MAX_COMP_RESET  = 8'd255;
    localparam logic [63:0] ALLOWED_0_RESET = 64'h03ff_6000_0000_0000;
    localparam logic [63:0] ALLOWED_1_RESET = 64'h07ff_fffe_87ff_fffe;
    localparam logic [63:0] ALLOWED_2_RESET = 64'h0;
    localparam logic [63:0] ALLOWED_3_RESET = 64'h0;

    // status of a closed component, keeps an earlier failure
    function automatic status_t close_err(
        input status_t                 first_err,
        input logic [COMP_CNT_W-1:0]   count,
        input logic                    all_dots,
        input logic                    bad_byte,
        input logic [7:0]              max_comp
    );
        status_t res;
        res = first_err;
        if (first_err == ST_OK)
        begin
            if (count == '0)
                res = ST_EMPTY_COMP;
            else if (count > {1'b0, max_comp})
                res = ST_COMP_TOO_LONG;
            else if (count == COMP_CNT_W'(2) && all_dots)
                res = ST_DOTDOT;
            else if (bad_byte)
                res = ST_BAD_BYTE;
        end
        return res;
    endfunction

endpackage

### hdl/absolute_path_validator.sv
// throughput: one byte per cycle, held off only while a last byte waits for a busy status output
// bytes pass an input register, then the counter and flag update into the status register
// reset (rst_n low, asynchronous) clears the path state and loads the register defaults
// the path state also returns to its reset values after every status
module absolute_path_validator (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] empty_path
    // status stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] status, [7:3] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import apv_pkg::*;

    // configuration registers
    logic [15:0] max_path_reg;
    logic [7:0]  max_comp_reg;
    logic [63:0] allowed_reg [4];

    // input register
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // path state
    logic                  at_first_reg, at_first_next;
    logic                  not_abs_reg, not_abs_next;
    logic [PATH_CNT_W-1:0] path_count_reg, path_count_next;
    logic                  null_reg, null_next;
    logic [COMP_CNT_W-1:0] comp_count_reg, comp_count_next;
    logic                  comp_dots_reg, comp_dots_next;
    logic                  comp_bad_reg, comp_bad_next;
    status_t               first_err_reg, first_err_next;

    // output register
    logic    out_valid_reg;
    status_t status_reg, status_next;

    logic       out_free;
    logic       adv;
    logic       byte_ok;
    logic       cfg_wr;
    reg_index_t cfg_idx;
    status_t    fin_err;

    assign out_free = !out_valid_reg || m_tready;
    assign adv      = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || adv;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, status_reg};

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    assign byte_ok = allowed_reg[in_ch_reg[7:6]][in_ch_reg[5:0]];

    always_comb
    begin
        case (cfg_idx)
            REG_MAX_PATH:  prdata = {48'd0, max_path_reg};
            REG_MAX_COMP:  prdata = {56'd0, max_comp_reg};
            REG_ALLOWED_0: prdata = allowed_reg[0];
            REG_ALLOWED_1: prdata = allowed_reg[1];
            REG_ALLOWED_2: prdata = allowed_reg[2];
            REG_ALLOWED_3: prdata = allowed_reg[3];
            default:       prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_path_reg   <= MAX_PATH_RESET;
            max_comp_reg   <= MAX_COMP_RESET;
            allowed_reg[0] <= ALLOWED_0_RESET;
            allowed_reg[1] <= ALLOWED_1_RESET;
            allowed_reg[2] <= ALLOWED_2_RESET;
            allowed_reg[3] <= ALLOWED_3_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MAX_PATH:  max_path_reg   <= pwdata[15:0];
                REG_MAX_COMP:  max_comp_reg   <= pwdata[7:0];
                REG_ALLOWED_0: allowed_reg[0] <= pwdata;
                REG_ALLOWED_1: allowed_reg[1] <= pwdata;
                REG_ALLOWED_2: allowed_reg[2] <= pwdata;
                REG_ALLOWED_3: allowed_reg[3] <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        at_first_next   = at_first_reg;
        not_abs_next    = not_abs_reg;
        path_count_next = path_count_reg;
        null_next       = null_reg;
        comp_count_next = comp_count_reg;
        comp_dots_next  = comp_dots_reg;
        comp_bad_next   = comp_bad_reg;
        first_err_next  = first_err_reg;
        status_next     = ST_OK;
        fin_err         = ST_OK;

        if (adv)
        begin
            if (!in_empty_reg)
            begin
                if (path_count_reg != PATH_COUNT_MAX)
                    path_count_next = path_count_reg + PATH_CNT_W'(1);
                if (in_ch_reg == NULL_BYTE)
                    null_next = 1'b1;
                if (at_first_reg)
                begin
                    at_first_next = 1'b0;
                    if (in_ch_reg != SLASH_BYTE)
                        not_abs_next = 1'b1;
                end
                else if (in_ch_reg == SLASH_BYTE)
                begin
                    first_err_next  = close_err(first_err_reg, comp_count_reg,
                                                comp_dots_reg, comp_bad_reg, max_comp_reg);
                    comp_count_next = '0;
                    comp_dots_next  = 1'b1;
                    comp_bad_next   = 1'b0;
                end
                else
                begin
                    if (comp_count_reg != COMP_COUNT_MAX)
                        comp_count_next = comp_count_reg + COMP_CNT_W'(1);
                    if (in_ch_reg != DOT_BYTE)
                        comp_dots_next = 1'b0;
                    if (!byte_ok)
                        comp_bad_next = 1'b1;
                end
            end

            if (in_last_reg)
            begin
                // a trailing component without a closing slash still counts
                fin_err = first_err_next;
                if (comp_count_next != '0)
                    fin_err = close_err(first_err_next, comp_count_next,
                                        comp_dots_next, comp_bad_next, max_comp_reg);
                if (at_first_next || not_abs_next)
                    status_next = ST_NOT_ABSOLUTE;
                else if (path_count_next > {1'b0, max_path_reg})
                    status_next = ST_TOO_LONG;
                else if (null_next)
                    status_next = ST_NULL_BYTE;
                else
                    status_next = fin_err;

                at_first_next   = 1'b1;
                not_abs_next    = 1'b0;
                path_count_next = '0;
                null_next       = 1'b0;
                comp_count_next = '0;
                comp_dots_next  = 1'b1;
                comp_bad_next   = 1'b0;
                first_err_next  = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            at_first_reg   <= 1'b1;
            not_abs_reg    <= 1'b0;
            path_count_reg <= '0;
            null_reg       <= 1'b0;
            comp_count_reg <= '0;
            comp_dots_reg  <= 1'b1;
            comp_bad_reg   <= 1'b0;
            first_err_reg  <= ST_OK;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (adv && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            at_first_reg   <= at_first_next;
            not_abs_reg    <= not_abs_next;
            path_count_reg <= path_count_next;
            null_reg       <= null_next;
            comp_count_reg <= comp_count_next;
            comp_dots_reg  <= comp_dots_next;
            comp_bad_reg   <= comp_bad_next;
            first_err_reg  <= first_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ch_reg    <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
        if (adv && in_last_reg)
            status_reg <= status_next;
    end

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input held off with an empty input register");

    a_last_waits_for_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_last_reg && !out_free |=> in_valid_reg && in_last_reg)
        else $error("last byte dropped while status slot busy");

    a_state_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_last_reg |=> at_first_reg && path_count_reg == '0
                               && comp_count_reg == '0 && first_err_reg == ST_OK)
        else $error("path state not cleared after end of path");

    a_comp_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        comp_count_reg != '0 |-> !at_first_reg && path_count_reg != '0)
        else $error("component bytes counted before first byte");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg ##1 out_valid_reg |-> $past(adv && in_last_reg))
        else $error("status issued without an end of path");

endmodule
